// ===== rtl/ipv4rhf_pkg.sv =====
// Package: payload types and protocol constants for the IPv4 receive header filter.
package ipv4rhf_pkg;

    // Frame byte stream transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ipv4rhf_in_t;

    // Per-frame verdict transaction
    typedef struct packed {
        logic        accepted;
        logic [31:0] accept_count;
        logic [31:0] drop_count;
    } ipv4rhf_out_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 8;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE        = 8'd0,
        CFG_LOCAL_ADDRESS = 8'd1
    } ipv4rhf_cfg_index_t;

    localparam logic [31:0] LOCAL_ADDRESS_RESET = 32'h0F02_000A;

    // Byte offsets within the Ethernet frame; the port offsets are within the UDP header
    localparam int unsigned OFF_ETHERTYPE_HI = 12;
    localparam int unsigned OFF_ETHERTYPE_LO = 13;
    localparam int unsigned OFF_IP_START     = 14;
    localparam int unsigned OFF_TOTLEN_HI    = 16;
    localparam int unsigned OFF_TOTLEN_LO    = 17;
    localparam int unsigned OFF_PROTOCOL     = 23;
    localparam int unsigned OFF_DST_FIRST    = 30;
    localparam int unsigned OFF_DST_LAST     = 33;
    localparam int unsigned OFF_PORT_HI      = 2;
    localparam int unsigned OFF_PORT_LO      = 3;

    // Header field values
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4     = 4'd4;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [15:0] BOOT_CLIENT_PORT = 16'd68;
    localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFF_FFFF;
    localparam logic [15:0] CHECKSUM_GOOD    = 16'hFFFF;
    localparam int unsigned MIN_FRAME_LEN    = 34;
    localparam int unsigned MIN_HEADER_LEN   = 20;
    localparam int unsigned UDP_HEADER_LEN   = 8;

    localparam int unsigned SUM_BITS = 21;

endpackage

// ===== rtl/ipv4_receive_header_filter.sv =====
// Top level: IPv4 receive header filter with checksum check and frame counters.
//
//  Channel  | Direction | Handshake             | Content
//  ---------+-----------+-----------------------+---------------------------------
//  rx       | in        | rx_valid / rx_ready   | data_byte, last_byte per byte
//  result   | out       | result_valid/_ready   | accepted, accept_count, drop_count
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (write only)
//
// Each byte is parsed into the header registers in the cycle it is taken, one
// byte per cycle while rx_ready is high. The edge that takes the last byte
// moves the header snapshot to a decision register; the verdict moves on to the
// result register, which drives result_valid, once that register is free. The
// decision stage and the result register let a new frame stream in while a
// verdict waits to be taken; rx_ready drops only while the decision stage holds
// a verdict and the result register is stalled. Reset clears the counters and
// the frame state and loads the reset local address; cfg_ready is always high.
module ipv4_receive_header_filter #(
    parameter int POSITION_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rx_valid,
    output logic                      rx_ready,
    input  ipv4rhf_pkg::ipv4rhf_in_t  rx_data,
    output logic                      result_valid,
    input  logic                      result_ready,
    output ipv4rhf_pkg::ipv4rhf_out_t result_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ipv4rhf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);
    import ipv4rhf_pkg::*;

    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};

    localparam logic [P-1:0] P_ETH_HI   = P'(OFF_ETHERTYPE_HI);
    localparam logic [P-1:0] P_ETH_LO   = P'(OFF_ETHERTYPE_LO);
    localparam logic [P-1:0] P_IP_START = P'(OFF_IP_START);
    localparam logic [P-1:0] P_TL_HI    = P'(OFF_TOTLEN_HI);
    localparam logic [P-1:0] P_TL_LO    = P'(OFF_TOTLEN_LO);
    localparam logic [P-1:0] P_PROTO    = P'(OFF_PROTOCOL);
    localparam logic [P-1:0] P_DST_LO   = P'(OFF_DST_FIRST);
    localparam logic [P-1:0] P_DST_HI   = P'(OFF_DST_LAST);

    // Configuration registers
    logic        enable_reg;
    logic [31:0] local_address_reg;

    // Per-frame parse state
    logic [P-1:0]          pos_reg,   pos_next;
    logic [15:0]           ek_reg,    ek_next;
    logic [7:0]            vl_reg,    vl_next;
    logic [15:0]           tl_reg,    tl_next;
    logic [7:0]            proto_reg, proto_next;
    logic [31:0]           dst_reg,   dst_next;
    logic [15:0]           port_reg,  port_next;
    logic                  seen_reg,  seen_next;
    logic [SUM_BITS-1:0]   sum_reg,   sum_next;
    logic [7:0]            hi_reg,    hi_next;

    // Decision stage snapshot
    logic                  dec_valid_reg, dec_valid_next;
    logic [P-1:0]          dec_len_reg;
    logic [15:0]           dec_ek_reg;
    logic [7:0]            dec_vl_reg;
    logic [15:0]           dec_tl_reg;
    logic [7:0]            dec_proto_reg;
    logic [31:0]           dec_dst_reg;
    logic [15:0]           dec_port_reg;
    logic                  dec_seen_reg;
    logic [SUM_BITS-1:0]   dec_sum_reg;

    // Counters and result register
    logic [31:0]  accept_total_reg, accept_total_next;
    logic [31:0]  drop_total_reg,   drop_total_next;
    logic         out_valid_reg,    out_valid_next;
    ipv4rhf_out_t out_data_reg,     out_data_next;

    logic take, take_last, out_free, dec_advance;

    // Handshake control
    assign out_free    = !out_valid_reg || result_ready;
    assign dec_advance = dec_valid_reg && out_free;
    assign rx_ready    = !dec_valid_reg || out_free;
    assign take        = rx_valid && rx_ready;
    assign take_last   = take && rx_data.last_byte;
    assign cfg_ready   = 1'b1;

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // Parse one byte into the header fields
    logic [7:0]   b;
    logic [7:0]   vl_eff;
    logic [5:0]   hl_eff;
    logic [P-1:0] off;
    logic [P-1:0] port_hi_pos, port_lo_pos;
    always_comb
    begin
        b           = rx_data.data_byte;
        pos_next    = pos_reg;
        ek_next     = ek_reg;
        vl_next     = vl_reg;
        tl_next     = tl_reg;
        proto_next  = proto_reg;
        dst_next    = dst_reg;
        port_next   = port_reg;
        seen_next   = seen_reg;
        sum_next    = sum_reg;
        hi_next     = hi_reg;
        vl_eff      = (pos_reg == P_IP_START) ? b : vl_reg;
        hl_eff      = {vl_eff[3:0], 2'b00};
        off         = pos_reg - P_IP_START;
        port_hi_pos = P_IP_START + P'(hl_eff) + P'(OFF_PORT_HI);
        port_lo_pos = P_IP_START + P'(hl_eff) + P'(OFF_PORT_LO);
        if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + P'(1);
            if (pos_reg == P_ETH_HI || pos_reg == P_ETH_LO)
                ek_next = {ek_reg[7:0], b};
            if (pos_reg == P_IP_START)
                vl_next = b;
            if (pos_reg == P_TL_HI || pos_reg == P_TL_LO)
                tl_next = {tl_reg[7:0], b};
            if (pos_reg == P_PROTO)
                proto_next = b;
            if (pos_reg >= P_DST_LO && pos_reg <= P_DST_HI)
                dst_next = {dst_reg[23:0], b};
            if (pos_reg >= P_IP_START)
            begin
                // Accumulate big-endian header words
                if (off < P'(hl_eff))
                begin
                    if (!off[0])
                        hi_next = b;
                    else
                        sum_next = sum_reg + SUM_BITS'({hi_reg, b});
                end
                if (pos_reg == port_hi_pos)
                    port_next = {b, port_reg[7:0]};
                if (pos_reg == port_lo_pos)
                begin
                    port_next = {port_reg[15:8], b};
                    seen_next = 1'b1;
                end
            end
        end
    end

    // Decide on the snapshot frame
    logic [5:0]  dec_hl;
    logic [16:0] dec_len_w, dec_tl_w, dec_hl_w;
    logic [16:0] fold1, fold2;
    logic        dhcp, addr_ok, hdr_ok, ok;
    always_comb
    begin
        dec_hl    = {dec_vl_reg[3:0], 2'b00};
        dec_len_w = 17'(dec_len_reg);
        dec_tl_w  = 17'(dec_tl_reg);
        dec_hl_w  = 17'(dec_hl);
        fold1     = 17'(dec_sum_reg[15:0]) + 17'(dec_sum_reg[SUM_BITS-1:16]);
        fold2     = 17'(fold1[15:0]) + 17'(fold1[16]);
        dhcp      = dec_proto_reg == PROTO_UDP
                 && dec_tl_w >= dec_hl_w + 17'(UDP_HEADER_LEN)
                 && dec_seen_reg && dec_port_reg == BOOT_CLIENT_PORT;
        addr_ok   = dec_dst_reg == local_address_reg
                 || dec_dst_reg == BROADCAST_ADDR || dhcp;
        hdr_ok    = enable_reg
                 && dec_len_w >= 17'(MIN_FRAME_LEN)
                 && dec_ek_reg == ETHERTYPE_IPV4
                 && dec_vl_reg[7:4] == IP_VERSION_4
                 && dec_hl >= 6'(MIN_HEADER_LEN)
                 && dec_len_w >= 17'(OFF_IP_START) + dec_hl_w
                 && dec_tl_w >= dec_hl_w
                 && dec_tl_w <= dec_len_w
                 && fold2 == 17'(CHECKSUM_GOOD);
        ok        = hdr_ok && addr_ok;
    end

    // Advance counters, decision stage and result register
    always_comb
    begin
        accept_total_next = accept_total_reg;
        drop_total_next   = drop_total_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;
        dec_valid_next    = dec_valid_reg;
        if (dec_advance)
            dec_valid_next = 1'b0;
        if (take_last)
            dec_valid_next = 1'b1;
        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;
        if (dec_advance)
        begin
            if (ok)
                accept_total_next = accept_total_reg + 32'd1;
            else
                drop_total_next = drop_total_reg + 32'd1;
            out_valid_next             = 1'b1;
            out_data_next.accepted     = ok;
            out_data_next.accept_count = accept_total_next;
            out_data_next.drop_count   = drop_total_next;
        end
    end

    // Hold control state, frame state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            local_address_reg <= LOCAL_ADDRESS_RESET;
            pos_reg           <= '0;
            ek_reg            <= '0;
            vl_reg            <= '0;
            tl_reg            <= '0;
            proto_reg         <= '0;
            dst_reg           <= '0;
            port_reg          <= '0;
            seen_reg          <= 1'b0;
            sum_reg           <= '0;
            hi_reg            <= '0;
            dec_valid_reg     <= 1'b0;
            accept_total_reg  <= '0;
            drop_total_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            // Write configuration
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ENABLE:        enable_reg        <= cfg_data[0];
                    CFG_LOCAL_ADDRESS: local_address_reg <= cfg_data;
                    default:           ;
                endcase
            end
            // Drop frame state after the last byte
            if (take_last)
            begin
                pos_reg   <= '0;
                ek_reg    <= '0;
                vl_reg    <= '0;
                tl_reg    <= '0;
                proto_reg <= '0;
                dst_reg   <= '0;
                port_reg  <= '0;
                seen_reg  <= 1'b0;
                sum_reg   <= '0;
                hi_reg    <= '0;
            end
            else if (take)
            begin
                pos_reg   <= pos_next;
                ek_reg    <= ek_next;
                vl_reg    <= vl_next;
                tl_reg    <= tl_next;
                proto_reg <= proto_next;
                dst_reg   <= dst_next;
                port_reg  <= port_next;
                seen_reg  <= seen_next;
                sum_reg   <= sum_next;
                hi_reg    <= hi_next;
            end
            dec_valid_reg    <= dec_valid_next;
            accept_total_reg <= accept_total_next;
            drop_total_reg   <= drop_total_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Capture snapshot and result payload
    always_ff @(posedge clk)
    begin
        if (take_last)
        begin
            dec_len_reg   <= pos_next;
            dec_ek_reg    <= ek_next;
            dec_vl_reg    <= vl_next;
            dec_tl_reg    <= tl_next;
            dec_proto_reg <= proto_next;
            dec_dst_reg   <= dst_next;
            dec_port_reg  <= port_next;
            dec_seen_reg  <= seen_next;
            dec_sum_reg   <= sum_next;
        end
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/ipv4rhf_checker.sv =====
// Checker: port-level assertions for the IPv4 receive header filter, with its bind.
module ipv4rhf_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      rx_valid,
    input logic                      rx_ready,
    input ipv4rhf_pkg::ipv4rhf_in_t  rx_data,
    input logic                      result_valid,
    input logic                      result_ready,
    input ipv4rhf_pkg::ipv4rhf_out_t result_data,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [ipv4rhf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input logic [31:0]               cfg_data
);
    import ipv4rhf_pkg::*;

    logic        enable_reg;
    logic [31:0] total_reg;
    logic [31:0] pending_reg, pending_next;

    // Count last-byte transactions not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (rx_valid && rx_ready && rx_data.last_byte)
            pending_next = pending_next + 32'd1;
        if (result_valid && result_ready)
            pending_next = pending_next - 32'd1;
    end

    // Track enable, the running frame total and the pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            total_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index == CFG_ENABLE)
                enable_reg <= cfg_data[0];
            if (result_valid && result_ready)
                total_reg <= total_reg + 32'd1;
            pending_reg <= pending_next;
        end
    end

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result dropped or changed while stalled");

    // Advance the counters by exactly one frame per transaction
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result_data.accept_count + result_data.drop_count == total_reg + 32'd1)
        else $error("frame counters out of step");

    // Drop every frame while disabled
    a_disabled_drop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !enable_reg |-> !result_data.accepted)
        else $error("frame accepted while disabled");

    // Show no result without a pending last byte
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 32'd0)
        else $error("result without a frame");

endmodule

bind ipv4_receive_header_filter ipv4rhf_checker u_ipv4rhf_checker (.*);
